// ===== rtl/tlpq_pkg.sv =====
// Package for the three-level priority task queue.
// Holds the field widths, operation, status and level codes, the controller state type
// and the command struct. It has no dependencies.
package tlpq_pkg;

  localparam int unsigned DefQueueDepth = 16;
  localparam int unsigned DefTaskWidth  = 32;

  localparam int unsigned IdWidth     = 32;
  localparam int unsigned PrioWidth   = 2;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned NumLevels   = 3;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_GET = 1'b1;

  localparam logic [StatusWidth-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusWidth-1:0] STATUS_BAD_PRIO = 2'd1;
  localparam logic [StatusWidth-1:0] STATUS_FULL     = 2'd2;
  localparam logic [StatusWidth-1:0] STATUS_EMPTY    = 2'd3;

  localparam logic [PrioWidth-1:0] LEVEL_NONE   = 2'd0;
  localparam logic [PrioWidth-1:0] LEVEL_HIGH   = 2'd1;
  localparam logic [PrioWidth-1:0] LEVEL_MEDIUM = 2'd2;
  localparam logic [PrioWidth-1:0] LEVEL_LOW    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the fields of an accepted transaction
    logic exec;  // update the queues and register the result
  } cmd_t;

endpackage

// ===== rtl/tlpq_ctrl.sv =====
// Controller state machine of the three-level priority task queue.
// Sequences capture, execution and the result strobe. Depends on tlpq_pkg.
module tlpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output tlpq_pkg::cmd_t    cmd_o
);

  tlpq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlpq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlpq_pkg::ST_IDLE: begin
        if (start_i) state_d = tlpq_pkg::ST_EXEC;
      end
      tlpq_pkg::ST_EXEC: begin
        state_d = tlpq_pkg::ST_RESP;
      end
      tlpq_pkg::ST_RESP: begin
        // A new transaction may be taken while the result is on the ports.
        state_d = start_i ? tlpq_pkg::ST_EXEC : tlpq_pkg::ST_IDLE;
      end
      default: begin
        state_d = tlpq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o     = 1'b0;
    done_o     = 1'b0;
    cmd_o.exec = 1'b0;
    unique case (state_q)
      tlpq_pkg::ST_IDLE: begin
      end
      tlpq_pkg::ST_EXEC: begin
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
      end
      tlpq_pkg::ST_RESP: begin
        done_o = 1'b1;
      end
      default: begin
      end
    endcase
    cmd_o.load = start_i && !busy_o;
  end

endmodule

// ===== rtl/tlpq_store.sv =====
// Task store of one priority level: a simple dual-port memory with registered read data.
// Depends on nothing but its parameters.
module tlpq_store #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TASK_WIDTH  = 32,
  localparam int unsigned PtrWidth   = $clog2(QUEUE_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [PtrWidth-1:0]   waddr_i,
  input  logic [TASK_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [PtrWidth-1:0]   raddr_i,
  output logic [TASK_WIDTH-1:0] rdata_o
);

  logic [TASK_WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [TASK_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tlpq_datapath.sv =====
// Datapath of the three-level priority task queue: captured fields, pointers, fill counts,
// the three task stores and the result registers. Depends on tlpq_pkg and tlpq_store.
module tlpq_datapath #(
  parameter int unsigned QUEUE_DEPTH = tlpq_pkg::DefQueueDepth,
  parameter int unsigned TASK_WIDTH  = tlpq_pkg::DefTaskWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tlpq_pkg::cmd_t                      cmd_i,
  input  logic                                op_i,
  input  logic [tlpq_pkg::PrioWidth-1:0]      priority_req_i,
  input  logic [tlpq_pkg::IdWidth-1:0]        task_id_i,
  output logic [tlpq_pkg::StatusWidth-1:0]    status_o,
  output logic [tlpq_pkg::IdWidth-1:0]        task_out_o,
  output logic [tlpq_pkg::PrioWidth-1:0]      level_out_o,
  output logic                                all_empty_o
);

  localparam int unsigned PtrWidth = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned Levels   = tlpq_pkg::NumLevels;

  logic                                op_q;
  logic [tlpq_pkg::PrioWidth-1:0]      prio_q;
  logic [tlpq_pkg::IdWidth-1:0]        task_q;

  logic [PtrWidth-1:0] head_q [Levels];
  logic [PtrWidth-1:0] head_d [Levels];
  logic [PtrWidth-1:0] tail_q [Levels];
  logic [PtrWidth-1:0] tail_d [Levels];
  logic [CntWidth-1:0] cnt_q  [Levels];
  logic [CntWidth-1:0] cnt_d  [Levels];

  logic [tlpq_pkg::StatusWidth-1:0] status_q, status_d;
  logic [tlpq_pkg::PrioWidth-1:0]   level_q, level_d;

  logic [Levels-1:0]     add_hit;
  logic [Levels-1:0]     get_hit;
  logic [TASK_WIDTH-1:0] wdata;
  logic [TASK_WIDTH-1:0] rdata [Levels];
  logic [63:0]           task_wide;
  logic [63:0]           read_wide;

  // A task is kept to its low TASK_WIDTH bits, zero-extended when the store is wider.
  assign task_wide = 64'(task_q);
  assign wdata     = task_wide[TASK_WIDTH-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      prio_q <= priority_req_i;
      task_q <= task_id_i;
    end
  end

  always_comb begin
    logic higher_busy;
    higher_busy = 1'b0;
    status_d    = tlpq_pkg::STATUS_OK;
    level_d     = tlpq_pkg::LEVEL_NONE;
    for (int l = 0; l < Levels; l++) begin
      add_hit[l] = (op_q == tlpq_pkg::OP_ADD) && (prio_q == tlpq_pkg::PrioWidth'(l + 1))
                   && (cnt_q[l] != CntWidth'(QUEUE_DEPTH));
      // Strict priority: a level is served only when every higher level is empty.
      get_hit[l] = (op_q == tlpq_pkg::OP_GET) && (cnt_q[l] != '0) && !higher_busy;
      if (cnt_q[l] != '0) higher_busy = 1'b1;

      head_d[l] = head_q[l];
      tail_d[l] = tail_q[l];
      cnt_d[l]  = cnt_q[l];
      if (add_hit[l]) begin
        tail_d[l] = (tail_q[l] == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : tail_q[l] + 1'b1;
        cnt_d[l]  = cnt_q[l] + 1'b1;
      end
      if (get_hit[l]) begin
        head_d[l] = (head_q[l] == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : head_q[l] + 1'b1;
        cnt_d[l]  = cnt_q[l] - 1'b1;
        level_d   = tlpq_pkg::PrioWidth'(l + 1);
      end
    end

    if (op_q == tlpq_pkg::OP_ADD) begin
      if (prio_q == tlpq_pkg::LEVEL_NONE) begin
        status_d = tlpq_pkg::STATUS_BAD_PRIO;
      end else if (add_hit == '0) begin
        status_d = tlpq_pkg::STATUS_FULL;
      end
    end else if (get_hit == '0) begin
      status_d = tlpq_pkg::STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < Levels; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else if (cmd_i.exec) begin
      for (int l = 0; l < Levels; l++) begin
        head_q[l] <= head_d[l];
        tail_q[l] <= tail_d[l];
        cnt_q[l]  <= cnt_d[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      level_q  <= level_d;
    end
  end

  for (genvar g = 0; g < Levels; g++) begin : g_store
    tlpq_store #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .TASK_WIDTH (TASK_WIDTH)
    ) u_store (
      .clk_i  (clk_i),
      .we_i   (cmd_i.exec && add_hit[g]),
      .waddr_i(tail_q[g]),
      .wdata_i(wdata),
      .re_i   (cmd_i.exec),
      .raddr_i(head_q[g]),
      .rdata_o(rdata[g])
    );
  end

  // Every store reads its head during execution; the served level picks one.
  always_comb begin
    unique case (level_q)
      tlpq_pkg::LEVEL_HIGH:   read_wide = 64'(rdata[0]);
      tlpq_pkg::LEVEL_MEDIUM: read_wide = 64'(rdata[1]);
      tlpq_pkg::LEVEL_LOW:    read_wide = 64'(rdata[2]);
      default:                read_wide = '0;
    endcase
  end

  assign status_o    = status_q;
  assign level_out_o = level_q;
  assign task_out_o  = read_wide[tlpq_pkg::IdWidth-1:0];
  assign all_empty_o = (cnt_q[0] == '0) && (cnt_q[1] == '0) && (cnt_q[2] == '0);

endmodule

// ===== rtl/three_level_priority_task_queue.sv =====
// Three-level strict-priority task queue, top level. Depends on tlpq_pkg, tlpq_ctrl,
// tlpq_datapath and tlpq_store.
// A transaction accepted while idle or in ST_RESP is captured into the field registers,
// executed in ST_EXEC and shows its result, with done_o high, in ST_RESP; the receiver
// cannot stall it. A new transaction can be taken while a result is shown in ST_RESP,
// but not in ST_EXEC, where busy_o is high. Reset clears the controller, pointers and
// fill counts; the task stores are undefined until written and need no clearing pass.
module three_level_priority_task_queue #(
  parameter int unsigned QUEUE_DEPTH = tlpq_pkg::DefQueueDepth,
  parameter int unsigned TASK_WIDTH  = tlpq_pkg::DefTaskWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             op_i,
  input  logic [tlpq_pkg::PrioWidth-1:0]   priority_req_i,
  input  logic [tlpq_pkg::IdWidth-1:0]     task_id_i,
  output logic                             done_o,
  output logic [tlpq_pkg::StatusWidth-1:0] status_o,
  output logic [tlpq_pkg::IdWidth-1:0]     task_out_o,
  output logic [tlpq_pkg::PrioWidth-1:0]   level_out_o,
  output logic                             all_empty_o
);

  tlpq_pkg::cmd_t cmd;

  tlpq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  tlpq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TASK_WIDTH (TASK_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (op_i),
    .priority_req_i(priority_req_i),
    .task_id_i     (task_id_i),
    .status_o      (status_o),
    .task_out_o    (task_out_o),
    .level_out_o   (level_out_o),
    .all_empty_o   (all_empty_o)
  );

endmodule
